// ===== hdl/fcssl_pkg.sv =====
package fcssl_pkg;

	localparam int NUM_CH   = 4;
	localparam int CH_IDX_W = $clog2(NUM_CH);
	localparam int OFF_W    = 15;
	localparam int DUTY_W   = 14;
	localparam int STEP_W   = 7;
	localparam int SLEW_W   = 16;
	localparam int TGT_W    = 17;
	localparam int MASK_W   = 4;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam logic signed [OFF_W-1:0] INVALID_MARK = 15'sd10000;
	localparam logic [DUTY_W-1:0] DUTY_MIN     = 14'd500;
	localparam logic [DUTY_W-1:0] DUTY_MAX     = 14'd9500;
	localparam logic [DUTY_W-1:0] CENTER_RESET = 14'd4500;
	localparam logic [STEP_W-1:0] STEP_RESET   = 7'd55;

	typedef enum logic [2:0] {
		REG_CENTER0 = 3'd0,
		REG_CENTER1 = 3'd1,
		REG_CENTER2 = 3'd2,
		REG_CENTER3 = 3'd3,
		REG_INVERT  = 3'd4,
		REG_STEP    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DUTY_W-1:0] center;
		logic              invert;
		logic [STEP_W-1:0] step;
	} lane_cfg_t;

	typedef struct packed {
		logic              mark;
		logic [DUTY_W-1:0] duty;
		logic [DUTY_W-1:0] duty_next;
	} lane_stat_t;

endpackage

// ===== hdl/fcssl_lane.sv =====
module fcssl_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [fcssl_pkg::OFF_W-1:0]  offset,
	input  fcssl_pkg::lane_cfg_t                cfg,
	input  logic                                upd,
	output fcssl_pkg::lane_stat_t               stat
);
	import fcssl_pkg::*;

	localparam logic signed [TGT_W-1:0] LO = TGT_W'(DUTY_MIN);
	localparam logic signed [TGT_W-1:0] HI = TGT_W'(DUTY_MAX);

	logic signed [SLEW_W-1:0] slewed_q;
	logic        [DUTY_W-1:0] driven_q;

	logic signed [TGT_W-1:0] off_x, center_x, step_x, target, last, next;
	logic signed [TGT_W:0]   diff_up, diff_dn;
	logic        [DUTY_W-1:0] duty_c;

	always_comb begin
		off_x    = TGT_W'(offset);
		center_x = $signed({{(TGT_W-DUTY_W){1'b0}}, cfg.center});
		step_x   = $signed({{(TGT_W-STEP_W){1'b0}}, cfg.step});
		target   = cfg.invert ? (center_x - off_x) : (center_x + off_x);
		// zero slewed value restarts from the driven duty
		if (slewed_q == '0) begin
			last = $signed({{(TGT_W-DUTY_W){1'b0}}, driven_q});
		end else begin
			last = TGT_W'(slewed_q);
		end
		diff_up = (TGT_W+1)'(target) - (TGT_W+1)'(last);
		diff_dn = (TGT_W+1)'(last) - (TGT_W+1)'(target);
		if (diff_up > (TGT_W+1)'(step_x)) begin
			next = last + step_x;
		end else if (diff_dn > (TGT_W+1)'(step_x)) begin
			next = last - step_x;
		end else begin
			next = target;
		end
		if (next < LO) begin
			duty_c = DUTY_MIN;
		end else if (next > HI) begin
			duty_c = DUTY_MAX;
		end else begin
			duty_c = next[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slewed_q <= '0;
			driven_q <= CENTER_RESET;
		end else if (upd) begin
			slewed_q <= next[SLEW_W-1:0];
			driven_q <= duty_c;
		end
	end

	assign stat.mark      = (offset == INVALID_MARK);
	assign stat.duty      = driven_q;
	assign stat.duty_next = duty_c;

`ifndef SYNTHESIS
	a_driven_range: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> (driven_q >= DUTY_MIN) && (driven_q <= DUTY_MAX))
		else $error("driven duty left clamp range");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(slewed_q) && $stable(driven_q))
		else $error("lane state moved without update");

	a_zero_step: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && (cfg.step == '0)) |=> (slewed_q == $past(last[SLEW_W-1:0])))
		else $error("zero step moved the slewed value");
`endif

endmodule

// ===== hdl/fcssl_merge.sv =====
module fcssl_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  fcssl_pkg::lane_stat_t             stat [fcssl_pkg::NUM_CH],
	output logic                              upd,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fcssl_pkg::DUTY_W-1:0]      duty [fcssl_pkg::NUM_CH],
	output logic                              updated
);
	import fcssl_pkg::*;

	logic              valid_s1;
	logic              updated_s1;
	logic [DUTY_W-1:0] duty_s1 [NUM_CH];
	logic              mark_any;
	logic              in_fire;

	always_comb begin
		mark_any = 1'b0;
		for (int c = 0; c < NUM_CH; c++) begin
			mark_any = mark_any | stat[c].mark;
		end
	end

	assign in_ready = !valid_s1 || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign upd      = in_fire && !mark_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int c = 0; c < NUM_CH; c++) begin
				duty_s1[c] <= mark_any ? stat[c].duty : stat[c].duty_next;
			end
			updated_s1 <= !mark_any;
		end
	end

	assign out_valid = valid_s1;
	assign duty      = duty_s1;
	assign updated   = updated_s1;

`ifndef SYNTHESIS
	a_held_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mark_any) |=> (out_valid && !updated))
		else $error("held frame not flagged as held");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid)
		else $error("accepted beat produced no result");

	a_no_stray_update: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |-> !upd)
		else $error("lane update without accepted beat");
`endif

endmodule

// ===== hdl/four_channel_servo_slew_limiter.sv =====
// Four-channel servo slew limiter with output clamp.
//
// Input channel (in_valid/in_ready) carries one beat per frame: four signed
// offsets. An offset equal to 10000 on any channel marks the frame invalid;
// the beat then returns the last driven duties with updated=0 and no state
// changes. Otherwise each lane builds center +/- offset, limits the move
// against its last slewed value by max_step, clamps to 500..9500 and drives.
// Output channel (out_valid/out_ready) returns exactly one beat per input.
// The result appears in the cycle after acceptance, from an output
// register. Throughput: one beat per cycle while out_ready stays high; the
// four lanes work in parallel and the lane state loop (add, compare, select)
// is combinational. When the receiver stalls the output register holds
// and in_ready drops only while a result waits and out_ready is low.
// Reset (arst_n low): centers go to 4500, invert_mask to 0, max_step to 55,
// slewed values to zero, driven duties to 4500, the output goes empty.
// APB registers at 4*i: center_ch0..3, invert_mask, max_step. Write them
// only while no beat is in flight.
module four_channel_servo_slew_limiter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fcssl_pkg::ADDR_W-1:0]         paddr,
	input  logic [fcssl_pkg::DATA_W-1:0]         pwdata,
	output logic [fcssl_pkg::DATA_W-1:0]         prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [fcssl_pkg::OFF_W-1:0]   offset_ch0,
	input  logic signed [fcssl_pkg::OFF_W-1:0]   offset_ch1,
	input  logic signed [fcssl_pkg::OFF_W-1:0]   offset_ch2,
	input  logic signed [fcssl_pkg::OFF_W-1:0]   offset_ch3,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [fcssl_pkg::DUTY_W-1:0]         duty_ch0,
	output logic [fcssl_pkg::DUTY_W-1:0]         duty_ch1,
	output logic [fcssl_pkg::DUTY_W-1:0]         duty_ch2,
	output logic [fcssl_pkg::DUTY_W-1:0]         duty_ch3,
	output logic                                 updated
);
	import fcssl_pkg::*;

	// config registers
	logic [DUTY_W-1:0] center_q [NUM_CH];
	logic [MASK_W-1:0] invert_q;
	logic [STEP_W-1:0] step_q;

	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				center_q[c] <= CENTER_RESET;
			end
			invert_q <= '0;
			step_q   <= STEP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_INVERT: invert_q <= pwdata[MASK_W-1:0];
				REG_STEP:   step_q   <= pwdata[STEP_W-1:0];
				default: begin
					if (reg_idx inside {[REG_CENTER0:REG_CENTER3]}) begin
						center_q[reg_idx[CH_IDX_W-1:0]] <= pwdata[DUTY_W-1:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INVERT: prdata = DATA_W'(invert_q);
			REG_STEP:   prdata = DATA_W'(step_q);
			default: begin
				if (reg_idx inside {[REG_CENTER0:REG_CENTER3]}) begin
					prdata = DATA_W'(center_q[reg_idx[CH_IDX_W-1:0]]);
				end else begin
					prdata = '0;
				end
			end
		endcase
	end

	// lanes
	logic signed [OFF_W-1:0] offs [NUM_CH];
	lane_cfg_t               lcfg [NUM_CH];
	lane_stat_t              lstat [NUM_CH];
	logic                    upd;
	logic [DUTY_W-1:0]       duty [NUM_CH];

	assign offs[0] = offset_ch0;
	assign offs[1] = offset_ch1;
	assign offs[2] = offset_ch2;
	assign offs[3] = offset_ch3;

	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		assign lcfg[c].center = center_q[c];
		assign lcfg[c].invert = invert_q[c];
		assign lcfg[c].step   = step_q;

		fcssl_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.offset (offs[c]),
			.cfg    (lcfg[c]),
			.upd    (upd),
			.stat   (lstat[c])
		);
	end

	// frame check and output register
	fcssl_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.stat      (lstat),
		.upd       (upd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.duty      (duty),
		.updated   (updated)
	);

	assign duty_ch0 = duty[0];
	assign duty_ch1 = duty[1];
	assign duty_ch2 = duty[2];
	assign duty_ch3 = duty[3];

endmodule

// ===== sim/testbench.sv =====
module testbench;
	import fcssl_pkg::*;

	// Run shape
	localparam int PASSES       = 8;
	localparam int PASS_ITEMS   = 130;
	localparam int IDLE_PCT     = 67;
	localparam int BOTH_PCT     = 35;
	localparam int HOLD_CYCLES  = 60;   // long receiver hold-off, fills the block
	localparam int PRESSURE_AT  = 40;   // beat count within a pass that triggers it
	localparam int MAX_SHOWN    = 10;
	localparam int REG_STRIDE   = 4;    // byte spacing of the registers
	localparam int FULL_SCALE   = 10000;
	// Indexes past the register map; writes there must change nothing.
	localparam int SPARE_IDX0   = int'(REG_STEP) + 1;
	localparam int SPARE_IDX1   = int'(REG_STEP) + 2;

	typedef logic [NUM_CH-1:0][OFF_W-1:0] offs_t;

	typedef struct packed {
		logic [NUM_CH-1:0][DUTY_W-1:0] duty;
		logic                          updated;
	} duty_frame_t;

	typedef enum {ROW_FRAME, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		int                idx;
		logic [DATA_W-1:0] data;
		offs_t             offs;
		bit                pinned;    // want holds a hand-derived result
		duty_frame_t       want;
	} step_row_t;

	// DUT connections; every input known from time zero
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OFF_W-1:0]    offset_ch0 = '0;
	logic [OFF_W-1:0]    offset_ch1 = '0;
	logic [OFF_W-1:0]    offset_ch2 = '0;
	logic [OFF_W-1:0]    offset_ch3 = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DUTY_W-1:0]   duty_ch0;
	logic [DUTY_W-1:0]   duty_ch1;
	logic [DUTY_W-1:0]   duty_ch2;
	logic [DUTY_W-1:0]   duty_ch3;
	logic                updated;

	// Predictor copy of the block's registers and lane state
	logic [DUTY_W-1:0]   center_cfg [NUM_CH];
	logic [MASK_W-1:0]   invert_cfg;
	logic [STEP_W-1:0]   step_cfg;
	int                  slew_st    [NUM_CH];
	logic [DUTY_W-1:0]   drive_st   [NUM_CH];

	duty_frame_t         pending_duties [$];   // result beats still owed by the DUT
	int                  bad_beats = 0;
	int                  shown_bad = 0;
	int                  tx_idle_pct = 0;
	int                  rx_stall_pct = 0;
	int                  hold_req = 0;         // bumped to ask the receiver for a hold-off

	four_channel_servo_slew_limiter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.offset_ch0 (offset_ch0),
		.offset_ch1 (offset_ch1),
		.offset_ch2 (offset_ch2),
		.offset_ch3 (offset_ch3),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duty_ch0   (duty_ch0),
		.duty_ch1   (duty_ch1),
		.duty_ch2   (duty_ch2),
		.duty_ch3   (duty_ch3),
		.updated    (updated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// One frame through the lanes. A sentinel on any channel freezes all
	// state and repeats the last driven duties with updated low.
	function automatic duty_frame_t advance_servos(input offs_t off);
		duty_frame_t r;
		bit          hold;
		int          tgt, last, nxt;
		hold = 1'b0;
		for (int c = 0; c < NUM_CH; c++)
			if ($signed(off[c]) == INVALID_MARK)
				hold = 1'b1;
		if (!hold) begin
			for (int c = 0; c < NUM_CH; c++) begin
				tgt = int'(center_cfg[c]);
				tgt = invert_cfg[c] ? tgt - int'($signed(off[c])) : tgt + int'($signed(off[c]));
				last = slew_st[c];
				// zero slewed value restarts from the driven duty
				if (last == 0)
					last = int'(drive_st[c]);
				if (tgt - last > int'(step_cfg))
					nxt = last + int'(step_cfg);
				else if (last - tgt > int'(step_cfg))
					nxt = last - int'(step_cfg);
				else
					nxt = tgt;
				slew_st[c] = nxt;
				if (nxt < int'(DUTY_MIN))
					nxt = int'(DUTY_MIN);
				if (nxt > int'(DUTY_MAX))
					nxt = int'(DUTY_MAX);
				drive_st[c] = DUTY_W'(nxt);
			end
		end
		for (int c = 0; c < NUM_CH; c++)
			r.duty[c] = drive_st[c];
		r.updated = !hold;
		return r;
	endfunction

	function automatic offs_t pack_offs(input int o0, o1, o2, o3);
		offs_t o;
		o[0] = OFF_W'(o0);
		o[1] = OFF_W'(o1);
		o[2] = OFF_W'(o2);
		o[3] = OFF_W'(o3);
		return o;
	endfunction

	function automatic step_row_t f_row(input int o0, o1, o2, o3);
		step_row_t r;
		r.kind = ROW_FRAME;
		r.idx = 0;
		r.data = '0;
		r.offs = pack_offs(o0, o1, o2, o3);
		r.pinned = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic step_row_t p_row(input int o0, o1, o2, o3, d0, d1, d2, d3,
			input bit upd);
		step_row_t r;
		r = f_row(o0, o1, o2, o3);
		r.pinned = 1'b1;
		r.want.duty[0] = DUTY_W'(d0);
		r.want.duty[1] = DUTY_W'(d1);
		r.want.duty[2] = DUTY_W'(d2);
		r.want.duty[3] = DUTY_W'(d3);
		r.want.updated = upd;
		return r;
	endfunction

	function automatic step_row_t w_row(input int idx, input logic [DATA_W-1:0] data);
		step_row_t r;
		r = f_row(0, 0, 0, 0);
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	// APB write: setup, access, then idle with psel low so writes never chain
	// within a step. The predictor registers follow the same decode.
	task automatic write_reg(input int idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * REG_STRIDE);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx <= int'(REG_CENTER3))
			center_cfg[idx] = data[DUTY_W-1:0];
		else if (idx == int'(REG_INVERT))
			invert_cfg = data[MASK_W-1:0];
		else if (idx == int'(REG_STEP))
			step_cfg = data[STEP_W-1:0];
	endtask

	// Offer one frame beat, with a random gap first. Valid is left high on
	// return so back-to-back beats need no extra edge.
	task automatic send_frame(input offs_t o, input bit pinned, input duty_frame_t want);
		duty_frame_t calc;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		offset_ch0 <= o[0];
		offset_ch1 <= o[1];
		offset_ch2 <= o[2];
		offset_ch3 <= o[3];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		calc = advance_servos(o);
		pending_duties.push_back(pinned ? want : calc);
	endtask

	// Stop offering and wait for every owed result beat.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_duties.size() != 0)
			@(posedge clk);
	endtask

	// Register settings per pass: two of them sit at the extremes.
	task automatic load_pass_cfg(input int pass);
		logic [DUTY_W-1:0] ctr [NUM_CH];
		logic [MASK_W-1:0] msk;
		logic [STEP_W-1:0] stp;
		logic [DATA_W-1:0] d;
		for (int c = 0; c < NUM_CH; c++)
			ctr[c] = ($urandom_range(3) == 0) ? DUTY_W'($urandom()) :
				DUTY_W'($urandom_range(FULL_SCALE));
		msk = MASK_W'($urandom());
		stp = STEP_W'($urandom());
		case (pass)
			0: begin
				// low centers and fastest slew: zero targets get reached early
				for (int c = 0; c < NUM_CH; c++)
					ctr[c] = DUTY_W'($urandom_range(1000));
				stp = '1;
			end
			1: begin
				ctr[0] = '0;
				ctr[1] = DUTY_W'(FULL_SCALE);
				ctr[2] = '1;
				ctr[3] = DUTY_MAX;
				msk = '1;
				stp = '1;
			end
			2: begin
				msk = '0;
				stp = STEP_W'(1);
			end
			5: begin
				ctr[0] = DUTY_MIN;
				ctr[1] = DUTY_MAX;
				ctr[2] = '0;
				ctr[3] = '1;
				msk = MASK_W'(4'b1010);
				stp = '0;
			end
			default: ;
		endcase
		// junk in the unused upper bits must be dropped
		for (int c = 0; c < NUM_CH; c++) begin
			d = $urandom();
			d[DUTY_W-1:0] = ctr[c];
			write_reg(c, d);
		end
		d = $urandom();
		d[MASK_W-1:0] = msk;
		write_reg(REG_INVERT, d);
		d = $urandom();
		d[STEP_W-1:0] = stp;
		write_reg(REG_STEP, d);
	endtask

	// Random traffic. Mostly held targets so the slew settles, some of them
	// on an exact zero target to hit the restart-from-driven path; the rest
	// is raw noise, invalid bursts and unrelated in-range frames.
	task automatic run_traffic(input int n, input bit squeeze);
		offs_t base, o;
		int    sent, len, style, pick, v, c;
		sent = 0;
		while (sent < n) begin
			style = $urandom_range(99);
			len = (style < 60) ? $urandom_range(90, 10) : $urandom_range(8, 1);
			for (int ch = 0; ch < NUM_CH; ch++) begin
				pick = $urandom_range(9);
				if (pick < 4)
					v = $urandom_range(1200) - 600;
				else if (pick < 7)
					v = $urandom_range(2 * FULL_SCALE - 1) - FULL_SCALE;
				else
					v = invert_cfg[ch] ? int'(center_cfg[ch]) : -int'(center_cfg[ch]);
				base[ch] = OFF_W'(v);
			end
			for (int k = 0; k < len && sent < n; k++) begin
				if (style < 60) begin
					o = base;
					if ($urandom_range(9) == 0) begin
						c = $urandom_range(NUM_CH - 1);
						o[c] = o[c] + OFF_W'($urandom_range(6)) - OFF_W'(3);
					end
					if ($urandom_range(19) == 0)
						o[$urandom_range(NUM_CH - 1)] = INVALID_MARK;
				end else if (style < 80) begin
					for (int ch = 0; ch < NUM_CH; ch++)
						o[ch] = OFF_W'($urandom());
				end else if (style < 90) begin
					for (int ch = 0; ch < NUM_CH; ch++)
						o[ch] = OFF_W'($urandom());
					o[$urandom_range(NUM_CH - 1)] = INVALID_MARK;
				end else begin
					for (int ch = 0; ch < NUM_CH; ch++)
						o[ch] = OFF_W'($urandom_range(2 * FULL_SCALE - 1) - FULL_SCALE);
				end
				if (squeeze && sent == PRESSURE_AT)
					hold_req++;
				send_frame(o, 1'b0, '0);
				sent++;
			end
		end
	endtask

	task automatic flag_beat(input string what, input duty_frame_t want, got);
		bad_beats++;
		if (shown_bad < MAX_SHOWN) begin
			shown_bad++;
			$display("%s: expected %0d %0d %0d %0d upd=%0b, got %0d %0d %0d %0d upd=%0b",
				what, want.duty[0], want.duty[1], want.duty[2], want.duty[3], want.updated,
				got.duty[0], got.duty[1], got.duty[2], got.duty[3], got.updated);
		end
	endtask

	// Receiver: random stalls at the phase rate, plus a long hold-off on
	// request while the sender keeps pushing.
	initial begin : rx_side
		int hold_left;
		int hold_ack;
		hold_left = 0;
		hold_ack = 0;
		forever begin
			@(posedge clk);
			if (hold_ack != hold_req) begin
				hold_ack = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Result checker: each accepted beat against the oldest expectation,
	// field by field.
	always @(posedge clk) begin : result_chk
		duty_frame_t got, want;
		bit          bad;
		if (arst_n && out_valid && out_ready) begin
			got.duty[0] = duty_ch0;
			got.duty[1] = duty_ch1;
			got.duty[2] = duty_ch2;
			got.duty[3] = duty_ch3;
			got.updated = updated;
			if (pending_duties.size() == 0)
				flag_beat("beat with nothing pending", '0, got);
			else begin
				want = pending_duties.pop_front();
				bad = (got.updated !== want.updated);
				for (int c = 0; c < NUM_CH; c++)
					if (got.duty[c] !== want.duty[c])
						bad = 1'b1;
				if (bad)
					flag_beat("duty mismatch", want, got);
			end
		end
	end

	initial begin : main
		step_row_t tab [$];

		for (int c = 0; c < NUM_CH; c++) begin
			center_cfg[c] = CENTER_RESET;
			slew_st[c] = 0;
			drive_st[c] = CENTER_RESET;
		end
		invert_cfg = '0;
		step_cfg = STEP_RESET;

		// Directed rows. Reset config: centers 4500, no inversion, step 55.
		// held frame straight out of reset repeats the reset duties
		tab.push_back(p_row(INVALID_MARK, 0, 0, 0, 4500, 4500, 4500, 4500, 1'b0));
		// center writes before any valid frame leave the driven duty alone
		tab.push_back(w_row(REG_CENTER0, 6000));
		tab.push_back(w_row(REG_CENTER1, 3000));
		tab.push_back(p_row(0, 0, 0, INVALID_MARK, 4500, 4500, 4500, 4500, 1'b0));
		// first valid frame: zero slewed value starts from 4500, moves one step
		tab.push_back(p_row(0, 0, 0, 0, 4555, 4445, 4500, 4500, 1'b1));
		tab.push_back(p_row(0, INVALID_MARK, INVALID_MARK, 0, 4555, 4445, 4500, 4500, 1'b0));
		// offsets at the 15 bit extremes and just past the legal range
		tab.push_back(f_row(16383, -16384, 0, 0));
		tab.push_back(f_row(-16384, 16383, -FULL_SCALE, FULL_SCALE - 1));
		tab.push_back(f_row(INVALID_MARK, INVALID_MARK, INVALID_MARK, INVALID_MARK));
		tab.push_back(w_row(REG_STEP, 127));
		tab.push_back(w_row(REG_INVERT, 4'b0101));
		tab.push_back(f_row(16383, 16383, -16384, -16384));
		tab.push_back(f_row(-FULL_SCALE, -FULL_SCALE, FULL_SCALE - 1, FULL_SCALE - 1));
		// zero step freezes every lane
		tab.push_back(w_row(REG_STEP, 0));
		tab.push_back(f_row(100, -100, 5, -5));
		tab.push_back(f_row(0, 0, 0, 0));
		// centers outside 0..10000 are used as given, duty still clamped
		tab.push_back(w_row(REG_CENTER2, 16383));
		tab.push_back(w_row(REG_CENTER3, 0));
		tab.push_back(w_row(REG_STEP, 127));
		tab.push_back(f_row(0, 0, 0, 0));
		tab.push_back(f_row(-1, 1, -1, 1));
		tab.push_back(f_row(0, 0, INVALID_MARK, 0));
		// addresses past the map are ignored
		tab.push_back(w_row(SPARE_IDX0, 32'hFFFF_FFFF));
		tab.push_back(w_row(SPARE_IDX1, 32'hFFFF_FFFF));
		tab.push_back(f_row(FULL_SCALE - 1, 1 - FULL_SCALE, 1, -1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tab[i]) begin
			if (tab[i].kind == ROW_WRITE) begin
				drain();
				write_reg(tab[i].idx, tab[i].data);
			end else
				send_frame(tab[i].offs, tab[i].pinned, tab[i].want);
		end
		drain();

		// Random passes: no idling, sender idle, receiver stalls, both.
		for (int pass = 0; pass < PASSES; pass++) begin
			case (pass % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = IDLE_PCT;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = IDLE_PCT;
				end
				default: begin
					tx_idle_pct = BOTH_PCT;
					rx_stall_pct = BOTH_PCT;
				end
			endcase
			load_pass_cfg(pass);
			run_traffic(PASS_ITEMS, (pass % 4) == 0);
			drain();
		end

		// wait past the output register to catch stray beats
		repeat (5) @(posedge clk);
		if (bad_beats == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
